// ----- rtl/pcrc_pkg.sv -----
package pcrc_pkg;

  localparam int unsigned CrcW  = 32;
  localparam int unsigned ByteW = 8;
  localparam int unsigned IdxW  = 3;

  // Width selector as written to the width_code register.
  typedef enum logic [1:0] {
    WC_8    = 2'd0,
    WC_16   = 2'd1,
    WC_32   = 2'd2,
    WC_NONE = 2'd3
  } width_code_t;

  // Register indexes on the configuration port.
  localparam logic [IdxW-1:0] REG_POLY     = 3'd0;
  localparam logic [IdxW-1:0] REG_INIT     = 3'd1;
  localparam logic [IdxW-1:0] REG_WIDTH    = 3'd2;
  localparam logic [IdxW-1:0] REG_REFL_IN  = 3'd3;
  localparam logic [IdxW-1:0] REG_REFL_OUT = 3'd4;
  localparam logic [IdxW-1:0] REG_XOR_OUT  = 3'd5;

  localparam logic [CrcW-1:0] FULL_MASK    = 32'hFFFF_FFFF;
  localparam logic [CrcW-1:0] RST_POLY     = 32'h04C1_1DB7;
  localparam logic [CrcW-1:0] RST_INIT     = 32'hFFFF_FFFF;
  localparam logic [CrcW-1:0] RST_XOR_OUT  = 32'hFFFF_FFFF;

  typedef struct packed {
    logic [CrcW-1:0] poly_value;
    logic [CrcW-1:0] init_value;
    width_code_t     width_code;
    logic            reflect_input;
    logic            reflect_output;
    logic [CrcW-1:0] final_xor;
  } cfg_t;

  function automatic logic [ByteW-1:0] flip_byte(input logic [ByteW-1:0] v);
    logic [ByteW-1:0] r;
    r = ((v & 8'hF0) >> 4) | ((v & 8'h0F) << 4);
    r = ((r & 8'hCC) >> 2) | ((r & 8'h33) << 2);
    r = ((r & 8'hAA) >> 1) | ((r & 8'h55) << 1);
    return r;
  endfunction

  function automatic logic [CrcW-1:0] flip_word(input logic [CrcW-1:0] v);
    logic [CrcW-1:0] r;
    for (int k = 0; k < CrcW; k++) begin
      r[k] = v[CrcW-1-k];
    end
    return r;
  endfunction

endpackage

// ----- rtl/parametric_crc_engine.sv -----
// Parametric CRC engine, 8/16/32-bit register widths.
//
// Input channel (in_valid / in_stall): one message byte per word, with
// in_last_byte marking the final byte. The first byte after reset or after
// a last byte starts a new message from init_value.
// Output channel (out_valid / out_stall): one word carrying out_crc_value
// per message, sent for the last byte only.
// Config channel (cfg_valid / cfg_ready): cfg_index selects poly, init,
// width code, reflect in, reflect out, final xor (0..5); other indexes are
// ignored. cfg_ready is always high. Write only while the engine is idle.
// Path: a byte taken into the input register is processed from there; a
// last byte's CRC then goes to the result register and out_valid (two
// register stages: the input register and the result register).
// Throughput: one byte per clock unless out_stall holds a pending result.
// The eight XOR-shift steps are unrolled, input reg to running CRC / result.
// Stall: while out_stall holds a pending result, the input register holds
// its byte and in_stall rises only once that register is occupied, so one
// more byte is absorbed before back-pressure reaches the sender.
// Reset (rst_n low, synchronous): config returns to CRC-32 defaults, both
// channels empty, and the next byte starts a fresh message.
module parametric_crc_engine
  import pcrc_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,

  input  logic             in_valid,
  output logic             in_stall,
  input  logic [ByteW-1:0] in_data_byte,
  input  logic             in_last_byte,

  output logic             out_valid,
  input  logic             out_stall,
  output logic [CrcW-1:0]  out_crc_value,

  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic [IdxW-1:0]  cfg_index,
  input  logic [CrcW-1:0]  cfg_data
);

  cfg_t             cfg_r;

  // input register
  logic             s1_vld_r;
  logic [ByteW-1:0] s1_byte_r;
  logic             s1_last_r;

  // running state
  logic [CrcW-1:0]  crc_r;
  logic             mid_r;

  // result register
  logic             out_vld_r;
  logic [CrcW-1:0]  out_crc_r;

  logic             adv;
  logic [CrcW-1:0]  crc_next;
  logic [CrcW-1:0]  crc_result;

  assign cfg_ready     = 1'b1;
  assign adv           = !out_vld_r || !out_stall;
  assign in_stall      = s1_vld_r && !adv;
  assign out_valid     = out_vld_r;
  assign out_crc_value = out_crc_r;

  // config registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.poly_value     <= RST_POLY;
      cfg_r.init_value     <= RST_INIT;
      cfg_r.width_code     <= WC_32;
      cfg_r.reflect_input  <= 1'b1;
      cfg_r.reflect_output <= 1'b1;
      cfg_r.final_xor      <= RST_XOR_OUT;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_POLY:     cfg_r.poly_value     <= cfg_data;
        REG_INIT:     cfg_r.init_value     <= cfg_data;
        REG_WIDTH:    cfg_r.width_code     <= width_code_t'(cfg_data[1:0]);
        REG_REFL_IN:  cfg_r.reflect_input  <= cfg_data[0];
        REG_REFL_OUT: cfg_r.reflect_output <= cfg_data[0];
        REG_XOR_OUT:  cfg_r.final_xor      <= cfg_data;
        default: ;
      endcase
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
    end else if (!in_stall) begin
      s1_vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      s1_byte_r <= in_data_byte;
      s1_last_r <= in_last_byte;
    end
  end

  pcrc_core u_core (
    .cfg         (cfg_r),
    .crc_state   (crc_r),
    .mid_message (mid_r),
    .data_byte   (s1_byte_r),
    .crc_next    (crc_next),
    .crc_result  (crc_result)
  );

  // running CRC and framing
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      crc_r <= '0;
      mid_r <= 1'b0;
    end else if (adv && s1_vld_r) begin
      crc_r <= crc_next;
      mid_r <= !s1_last_r;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (adv) begin
      out_vld_r <= s1_vld_r && s1_last_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && s1_vld_r && s1_last_r) begin
      out_crc_r <= crc_result;
    end
  end

  // A new result only comes from a last byte leaving the input register.
  a_out_from_last: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_vld_r) |-> $past(s1_vld_r && s1_last_r))
    else $error("result appeared without a last byte");

  // Back-pressure only when the input register actually holds a byte.
  a_stall_needs_byte: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> s1_vld_r)
    else $error("input stalled with empty input register");

  // After a last byte is processed the next byte starts a new message.
  a_rearm: assert property (@(posedge clk) disable iff (!rst_n)
    (adv && s1_vld_r && s1_last_r) |=> !mid_r)
    else $error("engine did not rearm after last byte");

  // Unsupported width yields a zero CRC.
  a_none_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (adv && s1_vld_r && s1_last_r && cfg_r.width_code == WC_NONE)
      |=> (out_crc_r == '0))
    else $error("unsupported width gave nonzero CRC");

endmodule

// ----- rtl/pcrc_core.sv -----
module pcrc_core
  import pcrc_pkg::*;
(
  input  cfg_t             cfg,
  input  logic [CrcW-1:0]  crc_state,
  input  logic             mid_message,
  input  logic [ByteW-1:0] data_byte,
  output logic [CrcW-1:0]  crc_next,
  output logic [CrcW-1:0]  crc_result
);

  // Work left-aligned in 32 bits so one XOR-shift datapath serves all widths.
  always_comb begin
    logic [4:0]      shamt;
    logic [CrcW-1:0] crc_in;
    logic [CrcW-1:0] acc;
    logic [CrcW-1:0] poly_al;
    logic [CrcW-1:0] mask;
    logic [CrcW-1:0] pre;
    logic [ByteW-1:0] b;

    case (cfg.width_code)
      WC_8:    shamt = 5'd24;
      WC_16:   shamt = 5'd16;
      default: shamt = 5'd0;
    endcase

    mask    = FULL_MASK >> shamt;
    crc_in  = mid_message ? crc_state : cfg.init_value;
    acc     = crc_in << shamt;
    poly_al = cfg.poly_value << shamt;
    b       = cfg.reflect_input ? flip_byte(data_byte) : data_byte;
    acc     = acc ^ {b, {(CrcW-ByteW){1'b0}}};

    for (int i = 0; i < ByteW; i++) begin
      acc = acc[CrcW-1] ? ((acc << 1) ^ poly_al) : (acc << 1);
    end

    // Reversing the left-aligned word reflects across the active width.
    pre = cfg.reflect_output ? flip_word(acc) : (acc >> shamt);

    if (cfg.width_code == WC_NONE) begin
      crc_next   = crc_state;
      crc_result = '0;
    end else begin
      crc_next   = acc >> shamt;
      crc_result = (pre ^ cfg.final_xor) & mask;
    end
  end

endmodule

// ----- bench/crc_checker.sv -----
`timescale 1ns / 1ps

module crc_checker
  import pcrc_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,

  input  logic             in_valid,
  input  logic             in_stall,
  input  logic [ByteW-1:0] in_data_byte,
  input  logic             in_last_byte,

  input  logic             out_valid,
  input  logic             out_stall,
  input  logic [CrcW-1:0]  out_crc_value,

  input  logic             cfg_valid,
  input  logic             cfg_ready,
  input  logic [IdxW-1:0]  cfg_index,
  input  logic [CrcW-1:0]  cfg_data,

  output int               err_count,
  output int               crc_pending
);

  cfg_t            shadow_cfg;
  logic [CrcW-1:0] crc_acc;
  logic            in_message;
  logic [CrcW-1:0] crc_expect_q[$];

  // Reverse the low nbits of v; bits above stay zero.
  function automatic logic [CrcW-1:0] mirror_bits(input logic [CrcW-1:0] v,
                                                  input int unsigned nbits);
    logic [CrcW-1:0] r;
    r = '0;
    for (int k = 0; k < nbits; k++) begin
      r[nbits-1-k] = v[k];
    end
    return r;
  endfunction

  // Fold one byte into the running CRC, queue the final value on a last byte.
  task automatic absorb_byte(input logic [ByteW-1:0] data, input logic last);
    int unsigned     w;
    logic [CrcW-1:0] msk;
    logic [CrcW-1:0] c;
    logic [CrcW-1:0] b;
    logic [CrcW-1:0] res;
    case (shadow_cfg.width_code)
      WC_8:    w = 8;
      WC_16:   w = 16;
      WC_32:   w = 32;
      default: w = 0;
    endcase
    if (w == 0) begin
      // unsupported width: framing only, CRC left alone
      in_message = !last;
      if (last) crc_expect_q.push_back('0);
    end else begin
      msk = (w == 32) ? FULL_MASK : ((32'h1 << w) - 32'h1);
      c   = in_message ? (crc_acc & msk) : (shadow_cfg.init_value & msk);
      b   = {24'h0, data};
      if (shadow_cfg.reflect_input) b = mirror_bits(b, 8);
      c = c ^ (b << (w - 8));
      for (int i = 0; i < 8; i++) begin
        if (c[w-1]) c = (c << 1) ^ shadow_cfg.poly_value;
        else        c = c << 1;
        c = c & msk;
      end
      crc_acc = c;
      if (!last) begin
        in_message = 1'b1;
      end else begin
        in_message = 1'b0;
        res = shadow_cfg.reflect_output ? mirror_bits(c, w) : c;
        crc_expect_q.push_back((res ^ shadow_cfg.final_xor) & msk);
      end
    end
  endtask

  always @(posedge clk) begin : track
    logic [CrcW-1:0] want;
    if (!rst_n) begin
      shadow_cfg.poly_value     = RST_POLY;
      shadow_cfg.init_value     = RST_INIT;
      shadow_cfg.width_code     = WC_32;
      shadow_cfg.reflect_input  = 1'b1;
      shadow_cfg.reflect_output = 1'b1;
      shadow_cfg.final_xor      = RST_XOR_OUT;
      crc_acc    = '0;
      in_message = 1'b0;
      crc_expect_q.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_POLY:     shadow_cfg.poly_value     = cfg_data;
          REG_INIT:     shadow_cfg.init_value     = cfg_data;
          REG_WIDTH:    shadow_cfg.width_code     = width_code_t'(cfg_data[1:0]);
          REG_REFL_IN:  shadow_cfg.reflect_input  = cfg_data[0];
          REG_REFL_OUT: shadow_cfg.reflect_output = cfg_data[0];
          REG_XOR_OUT:  shadow_cfg.final_xor      = cfg_data;
          default: ;
        endcase
      end
      if (in_valid && !in_stall) absorb_byte(in_data_byte, in_last_byte);
      if (out_valid && !out_stall) begin
        if (crc_expect_q.size() == 0) begin
          $error("crc_value: unexpected word, actual %h", out_crc_value);
          err_count <= err_count + 1;
        end else begin
          want = crc_expect_q.pop_front();
          if (out_crc_value !== want) begin
            $error("crc_value mismatch: expected %h, actual %h", want, out_crc_value);
            err_count <= err_count + 1;
          end
        end
      end
    end
    crc_pending <= crc_expect_q.size();
  end

endmodule

// ----- bench/tb_parametric_crc_engine.sv -----
`timescale 1ns / 1ps

module tb_parametric_crc_engine;
  import pcrc_pkg::*;

  // index outside the register map, the engine must ignore it
  localparam logic [IdxW-1:0] REG_UNUSED = 3'd7;
  // receiver back-pressure stretch in cycles
  localparam int HOLD_CYCLES = 300;
  localparam int ITEM_TARGET = 500;

  logic             clk = 1'b0;
  logic             rst_n = 1'b0;

  logic             in_valid = 1'b0;
  logic             in_stall;
  logic [ByteW-1:0] in_data_byte = '0;
  logic             in_last_byte = 1'b0;

  logic             out_valid;
  logic             out_stall = 1'b0;
  logic [CrcW-1:0]  out_crc_value;

  logic             cfg_valid = 1'b0;
  logic             cfg_ready;
  logic [IdxW-1:0]  cfg_index = '0;
  logic [CrcW-1:0]  cfg_data = '0;

  int err_count;
  int crc_pending;
  int bytes_sent = 0;

  // shared between sender and receiver: no idling when set
  bit burst_mode = 1'b0;
  // sender asks the receiver for one long stall stretch
  bit hold_off = 1'b0;

  always #5 clk = ~clk;

  parametric_crc_engine i_dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_data_byte  (in_data_byte),
    .in_last_byte  (in_last_byte),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_crc_value (out_crc_value),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  crc_checker i_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_data_byte  (in_data_byte),
    .in_last_byte  (in_last_byte),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_crc_value (out_crc_value),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .err_count     (err_count),
    .crc_pending   (crc_pending)
  );

  // Mostly short gaps, now and then a long one.
  function automatic int idle_len(input int lo);
    int r;
    int n;
    r = $urandom_range(0, 99);
    if (r < 60)      n = $urandom_range(0, 2);
    else if (r < 92) n = $urandom_range(3, 8);
    else             n = $urandom_range(20, 60);
    if (n < lo) n = lo;
    return n;
  endfunction

  // Byte values lean on the extremes a bit.
  function automatic logic [ByteW-1:0] pick_byte();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return 8'h00;
    if (r == 1) return 8'hFF;
    return ByteW'($urandom);
  endfunction

  // Config words: zero, all ones, a common polynomial, or anything.
  function automatic logic [CrcW-1:0] pick_word();
    int r;
    r = $urandom_range(0, 7);
    case (r)
      0:       return '0;
      1:       return FULL_MASK;
      2:       return RST_POLY;
      3:       return 32'h0000_1021;
      4:       return 32'h0000_0007;
      default: return $urandom;
    endcase
  endfunction

  // Offer one word, hold it until taken, then maybe idle. With no gap the
  // valid stays up so the next call can present its word in the same step.
  task automatic send_byte(input logic [ByteW-1:0] data, input logic last);
    int gap;
    in_valid     <= 1'b1;
    in_data_byte <= data;
    in_last_byte <= last;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    bytes_sent++;
    gap = (burst_mode || $urandom_range(0, 1)) ? 0 : idle_len(0);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // One message; with close cleared the message is left open on purpose.
  task automatic send_message(input int len, input bit close);
    for (int i = 0; i < len; i++) begin
      send_byte(pick_byte(), close && (i == len - 1));
    end
  endtask

  // Register write, then cfg_valid low and a wait, so back-to-back writes never
  // lower and raise cfg_valid in the same step.
  task automatic write_reg(input logic [IdxW-1:0] idx, input logic [CrcW-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  // Narrow registers get junk in the unused upper bits.
  task automatic set_config(input logic [CrcW-1:0] poly, input logic [CrcW-1:0] init,
                            input width_code_t wc, input logic rin, input logic rout,
                            input logic [CrcW-1:0] xr);
    logic [CrcW-1:0] junk;
    write_reg(REG_POLY, poly);
    write_reg(REG_INIT, init);
    junk = $urandom;
    write_reg(REG_WIDTH, {junk[CrcW-1:2], wc});
    junk = $urandom;
    write_reg(REG_REFL_IN, {junk[CrcW-1:1], rin});
    junk = $urandom;
    write_reg(REG_REFL_OUT, {junk[CrcW-1:1], rout});
    write_reg(REG_XOR_OUT, xr);
  endtask

  // Stop offering, wait for every CRC, then keep clocking the pipe so
  // a byte with no result is fully absorbed before the next config write.
  task automatic drain(input int limit);
    int n;
    in_valid <= 1'b0;
    n = 0;
    @(posedge clk);
    while (crc_pending != 0 && n < limit) begin
      @(posedge clk);
      n++;
    end
    repeat (4) @(posedge clk);
  endtask

  // Receiver: random stall bursts, plus one long hold on request.
  initial begin
    forever begin
      @(posedge clk);
      if (hold_off) begin
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        out_stall <= 1'b0;
        hold_off = 1'b0;
      end else if (!burst_mode && $urandom_range(0, 99) < 30) begin
        out_stall <= 1'b1;
        repeat (idle_len(1)) @(posedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  // Stimulus and verdict.
  initial begin
    int phase;
    int msgs;
    int r;
    int len;
    width_code_t wc;

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset config is CRC-32: zero byte, all-ones byte, check string
    send_byte(8'h00, 1'b1);
    send_byte(8'hFF, 1'b1);
    for (int i = 0; i < 9; i++) begin
      send_byte(8'h31 + ByteW'(i), i == 8);
    end
    drain(5000);

    // unmapped index must change nothing
    write_reg(REG_UNUSED, $urandom);
    // plain CRC-8, no reflection
    set_config(32'h0000_0007, '0, WC_8, 1'b0, 1'b0, '0);
    send_byte(8'h00, 1'b1);
    send_byte(8'hFF, 1'b1);
    drain(5000);

    // 16-bit, input reflected only, two-byte message
    set_config(32'h0000_1021, FULL_MASK, WC_16, 1'b1, 1'b0, 32'h0000_FFFF);
    send_byte(8'hA5, 1'b0);
    send_byte(8'h5A, 1'b1);
    drain(5000);

    // unsupported width: framing tracked, every CRC is zero
    set_config(FULL_MASK, FULL_MASK, WC_NONE, 1'b1, 1'b1, FULL_MASK);
    send_byte(8'h12, 1'b0);
    send_byte(8'h34, 1'b1);
    send_byte(8'hFF, 1'b1);
    drain(5000);

    // width changed in the middle of a message
    set_config(RST_POLY, '0, WC_32, 1'b0, 1'b1, '0);
    send_byte(8'h81, 1'b0);
    drain(5000);
    write_reg(REG_WIDTH, {30'h0, WC_16});
    send_byte(8'h7E, 1'b1);
    // unsupported width for one byte mid-message, then narrow to 8 bits
    send_byte(8'h55, 1'b0);
    drain(5000);
    write_reg(REG_WIDTH, {30'h0, WC_NONE});
    send_byte(8'hAA, 1'b0);
    drain(5000);
    write_reg(REG_WIDTH, {30'h0, WC_8});
    send_byte(8'h0F, 1'b1);
    drain(5000);

    // random phases, each under a fresh setting
    phase = 0;
    while (bytes_sent < ITEM_TARGET) begin
      r = $urandom_range(0, 9);
      wc = (r < 3) ? WC_8 : (r < 6) ? WC_16 : (r < 9) ? WC_32 : WC_NONE;
      set_config(pick_word(), pick_word(), wc, 1'($urandom), 1'($urandom), pick_word());
      burst_mode = ($urandom_range(0, 3) == 0);

      if (phase == 1) begin
        // long receiver hold while single-byte messages keep coming,
        // so the engine fills up and pushes back on the sender
        burst_mode = 1'b1;
        hold_off = 1'b1;
        wait (out_stall);
        for (int i = 0; i < 30; i++) begin
          send_byte(pick_byte(), 1'b1);
        end
      end else begin
        msgs = $urandom_range(2, 12);
        for (int m = 0; m < msgs; m++) begin
          r = $urandom_range(0, 99);
          len = (r < 70) ? $urandom_range(1, 4) :
                (r < 95) ? $urandom_range(5, 12) : $urandom_range(13, 40);
          send_message(len, 1'b1);
        end
        // sometimes leave a message open across the next config change
        if ($urandom_range(0, 3) == 0) send_message($urandom_range(1, 3), 1'b0);
      end
      drain(5000);
      phase++;
    end

    burst_mode = 1'b0;
    drain(5000);
    repeat (8) @(posedge clk);

    if (err_count == 0 && crc_pending == 0) begin
      $display("tb_parametric_crc_engine: clean");
    end else begin
      $display("tb_parametric_crc_engine: errors");
    end
    $finish;
  end

  // Watchdog, far beyond the slowest legal run.
  initial begin
    #5_000_000;
    $display("tb_parametric_crc_engine: errors");
    $finish;
  end

endmodule

// ----- filelist.f -----
rtl/pcrc_pkg.sv
rtl/pcrc_core.sv
rtl/parametric_crc_engine.sv
bench/crc_checker.sv
bench/tb_parametric_crc_engine.sv
